// File: hw/rtl/ckee_pkg.sv
// Shared widths, codes and result type for the canonical k-mer edge extractor.
`timescale 1ns / 1ps
package ckee_pkg;

  localparam int unsigned MaxK    = 32;
  localparam int unsigned KmerW   = 2 * MaxK;
  localparam int unsigned ArcW    = 8;
  localparam int unsigned LenW    = 6;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam logic [LenW-1:0] KmerLenReset = 6'd31;

  // register index, taken from paddr[2]
  localparam logic RegKmerLength = 1'b0;

  typedef struct packed {
    logic [KmerW-1:0] canonical_kmer;
    logic [ArcW-1:0]  arc_bits;
    logic             last_of_read;
  } result_t;

endpackage

// File: hw/rtl/ckee_base_if.sv
// Input channel: one base word with its read-end flag.
`timescale 1ns / 1ps
interface ckee_base_if
  import ckee_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] base_code;
  logic       read_end;

  modport source (output valid, output base_code, output read_end, input ready);
  modport sink   (input valid, input base_code, input read_end, output ready);
endinterface

// File: hw/rtl/ckee_kmer_if.sv
// Output channel: one canonical k-mer word with adjacency mask.
`timescale 1ns / 1ps
interface ckee_kmer_if
  import ckee_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KmerW-1:0] canonical_kmer;
  logic [ArcW-1:0]  arc_bits;
  logic             last_of_read;

  modport source (output valid, output canonical_kmer, output arc_bits,
                  output last_of_read, input ready);
  modport sink   (input valid, input canonical_kmer, input arc_bits,
                  input last_of_read, output ready);
endinterface

// File: hw/rtl/canonical_kmer_edge_extract_core.sv
// Canonical k-mer extractor with de Bruijn adjacency bits: top level.
//
//  channel   dir  handshake      word
//  base_i    in   valid/ready    base_code[1:0], read_end
//  kmer_o    out  valid/ready    canonical_kmer[63:0], arc_bits[7:0], last_of_read
//  apb       in   psel/penable   kmer_length at byte address 0
//
// One base per cycle while the output queue has room: a base word is registered in
// the input register, then the window shift, reverse complement, compare and arc
// update write up to two results into a 4-entry output queue. The queue must have
// room for two words before a base leaves the input register, so a base that
// yields two words (read end) can stall the input when the sink is slow.
// Reset clears the read state, the queue and sets kmer_length to 31.
`timescale 1ns / 1ps
module canonical_kmer_edge_extract_core
  import ckee_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ckee_base_if.sink         base_i,
  ckee_kmer_if.source       kmer_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // ---------------- configuration ----------------
  logic [LenW-1:0] kmer_length_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegKmerLength);
  assign prdata = (paddr[2] == RegKmerLength) ? {{(DataW-LenW){1'b0}}, kmer_length_q}
                                              : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KmerLenReset;
    end else if (cfg_we) begin
      kmer_length_q <= pwdata[LenW-1:0];
    end
  end

  // ---------------- input register ----------------
  logic       s1_valid_q;
  logic [1:0] s1_base_q;
  logic       s1_end_q;
  logic       s1_fire;
  logic [QCntW-1:0] q_cnt_q;

  assign s1_fire      = s1_valid_q && (q_cnt_q <= QCntW'(QDepth - 2));
  assign base_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (base_i.ready) begin
      s1_valid_q <= base_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_i.ready && base_i.valid) begin
      s1_base_q <= base_i.base_code;
      s1_end_q  <= base_i.read_end;
    end
  end

  // ---------------- read state ----------------
  logic [KmerW-1:0] window_q, window_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [KmerW-1:0] held_kmer_q, held_kmer_d;
  logic             held_fwd_q, held_fwd_d;
  logic [ArcW-1:0]  held_arcs_q, held_arcs_d;
  logic             held_valid_q, held_valid_d;

  logic [LenW-1:0]  k_eff;
  logic [LenW-1:0]  k_m1;
  logic [LenW-1:0]  fb_pos;
  logic [LenW:0]    rc_shift;
  logic [KmerW-1:0] kmask;
  logic [KmerW-1:0] win_n;
  logic [KmerW-1:0] rc_full;
  logic [KmerW-1:0] rc;
  logic [KmerW-1:0] canon;
  logic             cur_fwd;
  logic [LenW-1:0]  cnt_n;
  logic             forms;
  logic [1:0]       fb_canon;
  logic [1:0]       fb_held;
  logic [2:0]       pbit;
  logic [2:0]       cbit;
  logic             emit_prev;
  logic             emit_last;
  logic [ArcW-1:0]  prev_arcs;
  logic [ArcW-1:0]  new_arcs;
  result_t          res_prev;
  result_t          res_last;

  always_comb begin
    if (kmer_length_q < LenW'(2)) begin
      k_eff = LenW'(2);
    end else if (kmer_length_q > LenW'(MaxK)) begin
      k_eff = LenW'(MaxK);
    end else begin
      k_eff = kmer_length_q;
    end
  end

  assign k_m1     = k_eff - LenW'(1);
  assign fb_pos   = {k_m1[LenW-2:0], 1'b0};
  assign rc_shift = (LenW+1)'(KmerW) - {k_eff, 1'b0};
  assign kmask    = {KmerW{1'b1}} >> rc_shift;
  assign win_n    = {window_q[KmerW-3:0], s1_base_q} & kmask;

  // complement of the pair-reversed window; upper unused bases land at the bottom
  always_comb begin
    for (int i = 0; i < MaxK; i++) begin
      rc_full[2*i +: 2] = ~win_n[KmerW-2-2*i +: 2];
    end
  end

  assign rc      = rc_full >> rc_shift;
  assign cur_fwd = (win_n >= rc);
  assign canon   = cur_fwd ? win_n : rc;

  assign cnt_n = (cnt_q < k_eff) ? cnt_q + LenW'(1) : cnt_q;
  assign forms = (cnt_n >= k_eff);

  assign fb_canon = canon[fb_pos +: 2];
  assign fb_held  = held_kmer_q[fb_pos +: 2];

  // orientation table for the pair (held, current)
  always_comb begin
    unique case ({held_fwd_q, cur_fwd})
      2'b11: begin
        pbit = {1'b0, canon[1:0]};
        cbit = {1'b1, ~fb_held};
      end
      2'b10: begin
        pbit = {1'b0, ~fb_canon};
        cbit = {1'b0, ~fb_held};
      end
      2'b01: begin
        pbit = {1'b1, canon[1:0]};
        cbit = {1'b1, held_kmer_q[1:0]};
      end
      default: begin
        pbit = {1'b1, ~fb_canon};
        cbit = {1'b0, held_kmer_q[1:0]};
      end
    endcase
  end

  assign emit_prev = forms && held_valid_q;
  assign prev_arcs = held_arcs_q | (ArcW'(1) << pbit);
  assign new_arcs  = held_valid_q ? (ArcW'(1) << cbit) : '0;
  assign emit_last = s1_end_q && (forms || held_valid_q);

  always_comb begin
    res_prev.canonical_kmer = held_kmer_q;
    res_prev.arc_bits       = prev_arcs;
    res_prev.last_of_read   = 1'b0;
    res_last.canonical_kmer = forms ? canon : held_kmer_q;
    res_last.arc_bits       = forms ? new_arcs : held_arcs_q;
    res_last.last_of_read   = 1'b1;
  end

  always_comb begin
    window_d     = window_q;
    cnt_d        = cnt_q;
    held_kmer_d  = held_kmer_q;
    held_fwd_d   = held_fwd_q;
    held_arcs_d  = held_arcs_q;
    held_valid_d = held_valid_q;
    if (cfg_we || (s1_fire && s1_end_q)) begin
      window_d     = '0;
      cnt_d        = '0;
      held_kmer_d  = '0;
      held_fwd_d   = 1'b0;
      held_arcs_d  = '0;
      held_valid_d = 1'b0;
    end else if (s1_fire) begin
      window_d = win_n;
      cnt_d    = cnt_n;
      if (forms) begin
        held_kmer_d  = canon;
        held_fwd_d   = cur_fwd;
        held_arcs_d  = new_arcs;
        held_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      cnt_q        <= '0;
      held_kmer_q  <= '0;
      held_fwd_q   <= 1'b0;
      held_arcs_q  <= '0;
      held_valid_q <= 1'b0;
    end else begin
      window_q     <= window_d;
      cnt_q        <= cnt_d;
      held_kmer_q  <= held_kmer_d;
      held_fwd_q   <= held_fwd_d;
      held_arcs_q  <= held_arcs_d;
      held_valid_q <= held_valid_d;
    end
  end

  // ---------------- output queue ----------------
  result_t          q_mem [QDepth];
  logic [QPtrW-1:0] q_wptr_q, q_rptr_q;
  logic [QCntW-1:0] q_cnt_d;
  logic [1:0]       q_wr_n;
  logic             q_pop;
  result_t          slot0;
  result_t          slot1;

  assign q_wr_n = s1_fire ? (2'(emit_prev) + 2'(emit_last)) : 2'd0;
  assign slot0  = emit_prev ? res_prev : res_last;
  assign slot1  = res_last;
  assign q_pop  = kmer_o.valid && kmer_o.ready;
  assign q_cnt_d = q_cnt_q + QCntW'(q_wr_n) - QCntW'(q_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wptr_q <= '0;
      q_rptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      q_wptr_q <= q_wptr_q + QPtrW'(q_wr_n);
      q_rptr_q <= q_rptr_q + QPtrW'(q_pop);
      q_cnt_q  <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_n != 2'd0) begin
      q_mem[q_wptr_q] <= slot0;
    end
    if (q_wr_n == 2'd2) begin
      q_mem[q_wptr_q + QPtrW'(1)] <= slot1;
    end
  end

  assign kmer_o.valid          = (q_cnt_q != '0);
  assign kmer_o.canonical_kmer = q_mem[q_rptr_q].canonical_kmer;
  assign kmer_o.arc_bits       = q_mem[q_rptr_q].arc_bits;
  assign kmer_o.last_of_read   = q_mem[q_rptr_q].last_of_read;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for canonical_kmer_edge_extract_core: base stream in, k-mer words out.
`timescale 1ns / 1ps
module tb_top
  import ckee_pkg::*;
();

  localparam logic [AddrW-1:0] KmerLenAddr = {RegKmerLength, 2'b00};
  localparam logic [AddrW-1:0] SpareAddr   = {~RegKmerLength, 2'b00};
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned PhaseItems   = 95;

  typedef struct packed {
    logic [1:0] base_code;
    logic       read_end;
  } base_word_t;

  typedef enum logic [1:0] {SinkOpen, SinkCoin, SinkPattern, SinkChoke} sink_mode_e;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  ckee_base_if base_if ();
  ckee_kmer_if kmer_if ();

  canonical_kmer_edge_extract_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .base_i  (base_if),
    .kmer_o  (kmer_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  base_word_t  base_words_q [$];
  result_t     kmer_expect_q [$];
  int unsigned err_cnt;

  // k-mer tracker state
  logic [LenW-1:0]  len_cfg;
  logic [KmerW-1:0] win_bases;
  logic [LenW-1:0]  seen_in_read;
  logic [KmerW-1:0] held_kmer;
  logic             held_fwd;
  logic [ArcW-1:0]  held_arcs;
  logic             held_valid;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    err_cnt++;
    if (err_cnt <= 30) begin
      $display("%0t ERROR %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  function automatic int unsigned eff_k_of(input logic [LenW-1:0] v);
    if (v < 2) return 2;
    if (v > MaxK) return MaxK;
    return 32'(v);
  endfunction

  function automatic logic [KmerW-1:0] rev_comp(input logic [KmerW-1:0] v,
                                                input int unsigned k);
    logic [KmerW-1:0] r;
    r = '0;
    for (int i = 0; i < k; i++) begin
      r = {r[KmerW-3:0], ~v[1:0]};
      v = v >> 2;
    end
    return r;
  endfunction

  function automatic logic [1:0] lead_base(input logic [KmerW-1:0] v, input int unsigned k);
    return 2'(v >> (2 * (k - 1)));
  endfunction

  function automatic void clear_read();
    win_bases    = '0;
    seen_in_read = '0;
    held_kmer    = '0;
    held_fwd     = 1'b0;
    held_arcs    = '0;
    held_valid   = 1'b0;
  endfunction

  task automatic track_base(input logic [1:0] code, input logic last);
    int unsigned      k;
    int unsigned      pbit;
    int unsigned      cbit;
    logic [KmerW-1:0] msk;
    logic [KmerW-1:0] rc;
    logic [KmerW-1:0] canon;
    logic             cur_fwd;
    logic [ArcW-1:0]  cur_arcs;
    result_t          r;
    k = eff_k_of(len_cfg);
    msk = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    win_bases = ((win_bases << 2) | KmerW'(code)) & msk;
    if (seen_in_read < k) seen_in_read++;
    if (seen_in_read >= k) begin
      rc = rev_comp(win_bases, k);
      canon = (win_bases >= rc) ? win_bases : rc;
      cur_fwd = (win_bases == canon);
      cur_arcs = '0;
      if (held_valid) begin
        // orientation table: forward side uses last base, reverse side 3 - first
        if (held_fwd && cur_fwd) begin
          pbit = canon[1:0];
          cbit = 3 - lead_base(held_kmer, k) + 4;
        end else if (held_fwd) begin
          pbit = 3 - lead_base(canon, k);
          cbit = 3 - lead_base(held_kmer, k);
        end else if (cur_fwd) begin
          pbit = canon[1:0] + 4;
          cbit = held_kmer[1:0] + 4;
        end else begin
          pbit = 3 - lead_base(canon, k) + 4;
          cbit = held_kmer[1:0];
        end
        held_arcs = held_arcs | (8'd1 << pbit);
        cur_arcs  = cur_arcs | (8'd1 << cbit);
        r.canonical_kmer = held_kmer;
        r.arc_bits       = held_arcs;
        r.last_of_read   = 1'b0;
        kmer_expect_q.push_back(r);
      end
      held_kmer  = canon;
      held_fwd   = cur_fwd;
      held_arcs  = cur_arcs;
      held_valid = 1'b1;
    end
    if (last) begin
      if (held_valid) begin
        r.canonical_kmer = held_kmer;
        r.arc_bits       = held_arcs;
        r.last_of_read   = 1'b1;
        kmer_expect_q.push_back(r);
      end
      clear_read();
    end
  endtask

  // base driver: bursts of random length, random gaps between them
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin : base_driver
    base_word_t w;
    logic       fire;
    fire = base_if.valid && base_if.ready;
    if (fire) track_base(base_if.base_code, base_if.read_end);
    if (!rst_ni) begin
      base_if.valid <= 1'b0;
    end else if (base_if.valid && !fire) begin
      // word still pending
    end else if (gap_left != 0) begin
      gap_left      <= gap_left - 1;
      base_if.valid <= 1'b0;
    end else if (base_words_q.size() != 0) begin
      w = base_words_q.pop_front();
      base_if.valid     <= 1'b1;
      base_if.base_code <= w.base_code;
      base_if.read_end  <= w.read_end;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      base_if.valid <= 1'b0;
    end
  end

  // sink stalls: the mode is redrawn each time the 6-bit tick counter wraps
  sink_mode_e stall_mode;
  logic [7:0] stall_pat;
  logic [5:0] stall_tick;

  always @(posedge clk_i) begin : sink_stall
    if (stall_tick == 0) begin
      stall_mode <= sink_mode_e'($urandom_range(0, 3));
      stall_pat  <= 8'($urandom_range(1, 255));
    end
    stall_tick <= stall_tick + 6'd1;
    case (stall_mode)
      SinkOpen:    kmer_if.ready <= 1'b1;
      SinkCoin:    kmer_if.ready <= 1'($urandom_range(0, 1));
      SinkPattern: kmer_if.ready <= stall_pat[stall_tick[2:0]];
      default:     kmer_if.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin : kmer_monitor
    result_t want;
    if (rst_ni && kmer_if.valid && kmer_if.ready) begin
      if (kmer_expect_q.size() == 0) begin
        report_mismatch("k-mer word with none expected", '0, kmer_if.canonical_kmer);
      end else begin
        want = kmer_expect_q.pop_front();
        if (kmer_if.canonical_kmer !== want.canonical_kmer)
          report_mismatch("canonical_kmer", want.canonical_kmer, kmer_if.canonical_kmer);
        if (kmer_if.arc_bits !== want.arc_bits)
          report_mismatch("arc_bits", 64'(want.arc_bits), 64'(kmer_if.arc_bits));
        if (kmer_if.last_of_read !== want.last_of_read)
          report_mismatch("last_of_read", 64'(want.last_of_read),
                          64'(kmer_if.last_of_read));
      end
    end
  end

  int unsigned idle_cycles;

  always @(posedge clk_i) begin : watchdog
    if ((base_if.valid && base_if.ready) || (kmer_if.valid && kmer_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[2] == RegKmerLength) begin
      len_cfg = data[LenW-1:0];
      clear_read();
    end
  endtask

  task automatic apb_check_len();
    logic [DataW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= KmerLenAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== DataW'(len_cfg))
      report_mismatch("kmer_length readback", 64'(len_cfg), 64'(got));
  endtask

  // block is idle once every queued base is taken and every word has come out
  task automatic wait_idle();
    do @(negedge clk_i);
    while (base_words_q.size() != 0 || base_if.valid || kmer_expect_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // seq holds n bases, first base in the top pair
  task automatic push_bases(input logic [63:0] seq, input int unsigned n, input logic ends);
    base_word_t w;
    for (int i = 0; i < n; i++) begin
      w.base_code = seq[2 * (n - 1 - i) +: 2];
      w.read_end  = ends && (i == n - 1);
      base_words_q.push_back(w);
    end
  endtask

  task automatic queue_reads(input int unsigned k, input int unsigned budget);
    int unsigned n_items;
    int unsigned len;
    int unsigned kind;
    int unsigned style;
    logic [1:0]  fill;
    base_word_t  w;
    n_items = 0;
    while (n_items < budget) begin
      kind  = $urandom_range(0, 9);
      style = $urandom_range(0, 7);
      fill  = 2'($urandom_range(0, 3));
      if (kind == 0) len = $urandom_range(1, 8);          // noise, random ends
      else if (kind == 1) len = $urandom_range(1, k - 1); // too short for a k-mer
      else len = k + $urandom_range(0, (k < 8) ? 12 : 24);
      for (int i = 0; i < len; i++) begin
        case (style)
          0:       w.base_code = fill;            // homopolymer
          1:       w.base_code = 2'(i + fill);    // ACGT repeat, palindromes
          default: w.base_code = 2'($urandom_range(0, 3));
        endcase
        w.read_end = (kind == 0) ? ($urandom_range(0, 3) == 0) : (i == len - 1);
        base_words_q.push_back(w);
      end
      n_items += len;
    end
  endtask

  initial begin : stimulus
    int unsigned      len_values [8];
    logic [DataW-1:0] wdata;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    base_if.valid     = 1'b0;
    base_if.base_code = 2'd0;
    base_if.read_end  = 1'b0;
    kmer_if.ready     = 1'b0;
    stall_mode    = SinkOpen;
    stall_pat     = 8'hff;
    stall_tick    = '0;
    burst_left    = 0;
    gap_left      = 0;
    idle_cycles   = 0;
    err_cnt       = 0;
    len_cfg       = KmerLenReset;
    clear_read();
    len_values = '{32, 2, 63, 1, 17, 33, 9, 31};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_check_len();

    // directed: k written as 0 runs as 2
    apb_write(KmerLenAddr, 32'd0);
    push_bases(64'h1b, 4, 1'b1);   // ACGT, CG is its own reverse complement
    push_bases(64'h0, 1, 1'b1);    // read shorter than k
    push_bases(64'hff, 4, 1'b1);   // all T
    push_bases(64'h99, 4, 1'b1);   // GCGC
    wait_idle();
    push_bases(64'h06, 3, 1'b0);   // ACG left open, then k is rewritten
    wait_idle();
    apb_write(KmerLenAddr, 32'd3);
    apb_write(SpareAddr, 32'd5);   // unmapped, must not touch anything
    apb_check_len();
    push_bases(64'h03, 4, 1'b1);   // AAAT
    push_bases(64'h3f, 3, 1'b1);   // TTT
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      wdata = $urandom;
      wdata[LenW-1:0] = len_values[p][LenW-1:0];
      apb_write(KmerLenAddr, wdata);
      apb_check_len();
      if (p == 3) begin
        // sender holds off until all words are out, then resumes
        queue_reads(eff_k_of(len_cfg), PhaseItems / 2);
        wait_idle();
        queue_reads(eff_k_of(len_cfg), PhaseItems / 2);
      end else begin
        queue_reads(eff_k_of(len_cfg), PhaseItems);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk_i);
    while (kmer_expect_q.size() != 0) begin
      report_mismatch("k-mer word never seen", kmer_expect_q[0].canonical_kmer, '0);
      void'(kmer_expect_q.pop_front());
    end
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
